// File: rtl/core/b32e_pkg.sv
`default_nettype none

package b32e_pkg;

  // Symbol queue between the front and back parts
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // ASCII codes of the output alphabet
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharA      = 8'h41;
  localparam logic [7:0] CharTwo    = 8'h32;
  localparam logic [4:0] LetterMax  = 5'd25;
  localparam logic [4:0] DigitFirst = 5'd26;

  // One 5-bit group on its way to the back part
  typedef struct packed {
    logic [4:0] val;
    logic       last;
  } sym_t;

  // Map a 5-bit group onto the Base32 alphabet
  function automatic logic [7:0] sym_to_ascii(input logic [4:0] v);
    logic [4:0] off;
    off = v - DigitFirst;
    if (v > LetterMax) begin
      return CharTwo + {3'b000, off};
    end
    return CharA + {3'b000, v};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/base32_stream_encoder_core.sv
// Path: a byte accepted at an edge passes the front's hold register, the queue
//   entry and the output character register before it shows on the result ports.
// Throughput: one result per cycle while pop is held, set by the single output
//   register; a byte gives one to three characters plus dashes.
// Reset (rst_ni low, asynchronous): pending bits, grouping state, queue and the
//   group_dashes register clear; the block is ready once rst_ni rises.
`default_nettype none

module base32_stream_encoder_core import b32e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_stream_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char_o,
  output logic            final_char_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i
);

  logic group_q;
  logic f_valid, f_ready;
  sym_t f_sym;
  logic b_valid, b_ready;
  sym_t b_sym;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      group_q <= cfg_data_i;
    end
  end

  // Split each byte into 5-bit groups
  b32e_front u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .full_o          (full),
    .data_byte_i,
    .end_of_stream_i,
    .sym_valid_o     (f_valid),
    .sym_ready_i     (f_ready),
    .sym_o           (f_sym)
  );

  // Decouple front and back
  b32e_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_sym),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_sym)
  );

  // Map to ASCII and insert dashes
  b32e_back u_back (
    .clk_i,
    .rst_ni,
    .group_dashes_i (group_q),
    .sym_valid_i    (b_valid),
    .sym_ready_o    (b_ready),
    .sym_i          (b_sym),
    .empty,
    .pop,
    .out_char_o,
    .final_char_o
  );

  // A dash never carries the final flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_char_o == CharDash) |-> !final_char_o)
    else $error("dash flagged as final character");

  // Two dashes never follow each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && (out_char_o == CharDash) |=> empty || (out_char_o != CharDash))
    else $error("dash followed by dash");

  // A new stream never opens with a dash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && final_char_o |=> empty || (out_char_o != CharDash))
    else $error("stream started with a dash");

endmodule

`default_nettype wire

// File: rtl/core/b32e_front.sv
`default_nettype none

module b32e_front import b32e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_stream_i,
  output logic            sym_valid_o,
  input  wire logic       sym_ready_i,
  output sym_t            sym_o
);

  // Carried-over bits between bytes (at most four)
  logic [3:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  // Groups of the current byte, left-justified in a 15-bit window
  logic [14:0] hold_lj_q, hold_lj_d;
  logic [1:0]  hold_left_q, hold_left_d;
  logic [1:0]  hold_idx_q, hold_idx_d;
  logic        hold_eos_q, hold_eos_d;

  logic [3:0]  cnt_total;
  logic [3:0]  lj_shift;
  logic [11:0] bits12;
  logic [11:0] lj12;
  logic [1:0]  n_full;
  logic [3:0]  rem4;
  logic [2:0]  rem;
  logic [1:0]  n_sym;
  logic [3:0]  left_bits;
  logic        accept;
  logic        sym_fire;

  // Classify the incoming byte: how many groups, what stays behind
  always_comb begin
    cnt_total = {1'b0, pend_cnt_q} + 4'd8;
    bits12    = {pend_bits_q, data_byte_i};
    lj_shift  = 4'd12 - cnt_total;
    lj12      = bits12 << lj_shift;
    n_full    = (cnt_total >= 4'd10) ? 2'd2 : 2'd1;
    rem4      = cnt_total - ((n_full == 2'd2) ? 4'd10 : 4'd5);
    rem       = rem4[2:0];
    n_sym     = n_full + {1'b0, (end_of_stream_i && (rem != 3'd0))};
    left_bits = bits12[3:0] & ((4'd1 << rem) - 4'd1);
  end

  // Hand out the held groups one per cycle while sym_ready_i is high
  always_comb begin
    sym_valid_o = (hold_left_q != 2'd0);
    sym_fire    = sym_valid_o && sym_ready_i;
    case (hold_idx_q)
      2'd0:    sym_o.val = hold_lj_q[14:10];
      2'd1:    sym_o.val = hold_lj_q[9:5];
      default: sym_o.val = hold_lj_q[4:0];
    endcase
    sym_o.last = hold_eos_q && (hold_left_q == 2'd1);
    full_o     = (hold_left_q > 2'd1) || ((hold_left_q == 2'd1) && !sym_ready_i);
    accept     = push_i && !full_o;
  end

  // Load a new byte or advance through the held one
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    hold_lj_d   = hold_lj_q;
    hold_left_d = hold_left_q;
    hold_idx_d  = hold_idx_q;
    hold_eos_d  = hold_eos_q;
    if (accept) begin
      hold_lj_d   = {lj12, 3'b000};
      hold_left_d = n_sym;
      hold_idx_d  = 2'd0;
      hold_eos_d  = end_of_stream_i;
      pend_bits_d = end_of_stream_i ? 4'd0 : left_bits;
      pend_cnt_d  = end_of_stream_i ? 3'd0 : rem;
    end else if (sym_fire) begin
      hold_left_d = hold_left_q - 2'd1;
      hold_idx_d  = hold_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      hold_lj_q   <= '0;
      hold_left_q <= '0;
      hold_idx_q  <= '0;
      hold_eos_q  <= 1'b0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      hold_lj_q   <= hold_lj_d;
      hold_left_q <= hold_left_d;
      hold_idx_q  <= hold_idx_d;
      hold_eos_q  <= hold_eos_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/b32e_fifo.sv
`default_nettype none

module b32e_fifo import b32e_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sym_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output sym_t      out_data_o
);

  sym_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0] count_q, count_d;
  logic           wr_en;
  logic           rd_en;

  // Flags and pointer updates
  always_comb begin
    in_ready_o  = (count_q != QCw'(QDepth));
    out_valid_o = (count_q != '0);
    out_data_o  = mem_q[rd_ptr_q];
    wr_en       = in_valid_i && in_ready_o;
    rd_en       = out_valid_o && out_ready_i;
    wr_ptr_d    = wr_en ? wr_ptr_q + QAw'(1) : wr_ptr_q;
    rd_ptr_d    = rd_en ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    count_d     = count_q + QCw'(wr_en) - QCw'(rd_en);
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/b32e_back.sv
`default_nettype none

module b32e_back import b32e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       group_dashes_i,
  input  wire logic       sym_valid_i,
  output logic            sym_ready_o,
  input  wire sym_t       sym_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char_o,
  output logic            final_char_o
);

  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       out_vld_q, out_vld_d;
  logic [1:0] cig_q, cig_d;
  logic       any_q, any_d;
  logic       dash_done_q, dash_done_d;
  logic       can_load;
  logic       dash_due;

  // With group_dashes_i set, emit a dash ahead of each four-character group but the stream's first, then the character
  always_comb begin
    char_d      = char_q;
    last_d      = last_q;
    cig_d       = cig_q;
    any_d       = any_q;
    dash_done_d = dash_done_q;
    sym_ready_o = 1'b0;
    can_load    = !out_vld_q || pop;
    out_vld_d   = out_vld_q && !pop;
    dash_due    = group_dashes_i && any_q && (cig_q == 2'd0) && !dash_done_q;
    if (sym_valid_i && can_load) begin
      out_vld_d = 1'b1;
      if (dash_due) begin
        char_d      = CharDash;
        last_d      = 1'b0;
        dash_done_d = 1'b1;
      end else begin
        sym_ready_o = 1'b1;
        char_d      = sym_to_ascii(sym_i.val);
        last_d      = sym_i.last;
        dash_done_d = 1'b0;
        cig_d       = sym_i.last ? 2'd0 : cig_q + 2'd1;
        any_d       = !sym_i.last;
      end
    end
  end

  assign empty        = !out_vld_q;
  assign out_char_o   = char_q;
  assign final_char_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q      <= '0;
      last_q      <= 1'b0;
      out_vld_q   <= 1'b0;
      cig_q       <= '0;
      any_q       <= 1'b0;
      dash_done_q <= 1'b0;
    end else begin
      char_q      <= char_d;
      last_q      <= last_d;
      out_vld_q   <= out_vld_d;
      cig_q       <= cig_d;
      any_q       <= any_d;
      dash_done_q <= dash_done_d;
    end
  end

endmodule

`default_nettype wire
